@@ rtl/narp_pkg.sv @@
// Package for the upward note arpeggiator: field widths, item layouts and constants.
// No dependencies; imported by note_arpeggiator_up.
`timescale 1ns / 1ps
package narp_pkg;

  localparam int CHAN_W    = 5;
  localparam int NOTE_W    = 7;
  localparam int VEL_W     = 7;
  localparam int CIDX_W    = 4;
  localparam int SPAN_W    = 3;
  localparam int TDATA_W   = 24;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int MAX_HELD_DEF = 8;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

  localparam logic [0:0] REG_CHANNEL_INDEX = 1'b0;
  localparam logic [0:0] REG_OCTAVE_SPAN   = 1'b1;

  localparam logic ACT_NOTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic KIND_PASS = 1'b0;
  localparam logic KIND_ARP  = 1'b1;

  typedef struct packed {
    logic              pad;
    logic              to_cv;
    logic              to_midi;
    logic              length_unknown;
    logic              is_off;
    logic [VEL_W-1:0]  note_velocity;
    logic [NOTE_W-1:0] note_number;
    logic [CHAN_W-1:0] note_channel;
  } narp_in_t;

  typedef struct packed {
    logic              pad;
    logic              out_cv;
    logic              out_midi;
    logic              out_length_unknown;
    logic              out_off;
    logic [VEL_W-1:0]  out_velocity;
    logic [NOTE_W-1:0] out_note;
    logic [CHAN_W-1:0] out_channel;
  } narp_out_t;

  // Twelve semitones per octave, built from two shifts.
  function automatic logic [NOTE_W-1:0] oct_to_semi(input logic [SPAN_W-1:0] oct);
    oct_to_semi = NOTE_W'({oct, 3'b000}) + NOTE_W'({oct, 2'b00});
  endfunction

endpackage

@@ rtl/note_arpeggiator_up.sv @@
// Upward arpeggiator over a sorted store of held notes, with note pass-through.
// Depends on narp_pkg; the held-note store is a small memory inside this module.
`timescale 1ns / 1ps
// Channel  Direction  Contents
// in_      slave      tuser: action; tdata: note event fields
// out_     master     tuser: kind; tdata: output note fields
// cfg_     APB slave  channel_index at 0x0, octave_span at 0x4
//
// A tick passes through ST_TICK_RD, ST_TICK_AD and ST_EMIT. A note-on steps ST_INS_RD and
// ST_INS_WR once for each entry moved up, and a note-off steps ST_REM_RD and ST_REM_WR once
// for each held entry, as the note store has a single read port. Other items go straight
// to ST_EMIT.
// Reset is synchronous and active low; the store needs no clearing pass.
// A result waits in its final state until the output register is free.
module note_arpeggiator_up
  import narp_pkg::*;
#(
  parameter int MAX_HELD = MAX_HELD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // note_channel, note_number, note_velocity, is_off,
                                         // length_unknown, to_midi, to_cv, zero pad
  input  logic               in_tuser,   // action
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // out_channel, out_note, out_velocity, out_off,
                                         // out_length_unknown, out_midi, out_cv, zero pad
  output logic               out_tuser,  // kind
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [APB_AW-1:0]  cfg_paddr,
  input  logic [APB_DW-1:0]  cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_HELD);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INS_RD  = 4'd1;
  localparam logic [3:0] ST_INS_WR  = 4'd2;
  localparam logic [3:0] ST_REM_RD  = 4'd3;
  localparam logic [3:0] ST_REM_WR  = 4'd4;
  localparam logic [3:0] ST_TICK_RD = 4'd5;
  localparam logic [3:0] ST_TICK_AD = 4'd6;
  localparam logic [3:0] ST_EMIT    = 4'd7;

  logic [NOTE_W-1:0] mem [MAX_HELD];
  logic [NOTE_W-1:0] mem_rd_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [NOTE_W-1:0] wr_data;

  logic [3:0]        state_r, state_nxt;
  logic [CIDX_W-1:0] cidx_r, cidx_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [SPAN_W-1:0] oct_r, oct_nxt;
  logic              run_r, run_nxt;
  logic [VEL_W-1:0]  lvel_r, lvel_nxt;
  logic              lmidi_r, lmidi_nxt;
  logic              lcv_r, lcv_nxt;
  logic [CW-1:0]     ka_r, ka_nxt;
  logic [CW-1:0]     kb_r, kb_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic [NOTE_W-1:0] semi_r, semi_nxt;
  logic              pend_r, pend_nxt;
  narp_out_t         res_r, res_nxt;
  logic              rkind_r, rkind_nxt;
  logic              ovalid_r, ovalid_nxt;
  narp_out_t         odata_r, odata_nxt;
  logic              okind_r, okind_nxt;

  narp_in_t          in_item;
  logic              in_acc;
  logic              cfg_wr;
  logic [CHAN_W-1:0] arp_chan;
  logic [CW:0]       oct_inc;
  logic [SPAN_W-1:0] oct_sel;
  logic [NOTE_W:0]   sum;

  assign in_item    = narp_in_t'(in_tdata);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign arp_chan   = CHAN_W'({1'b0, cidx_r}) + CHAN_W'(1);
  assign sum        = {1'b0, mem_rd_r} + {1'b0, semi_r};
  assign out_tvalid = ovalid_r;
  assign out_tdata  = TDATA_W'(odata_r);
  assign out_tuser  = okind_r;

  always_comb begin
    if (cfg_paddr[2] == REG_OCTAVE_SPAN) begin
      cfg_prdata = APB_DW'(span_r);
    end else begin
      cfg_prdata = APB_DW'(cidx_r);
    end
  end

  always_comb begin
    oct_inc = (pos_r >= count_r) ? (CW + 1)'(oct_r) + (CW + 1)'(1) : (CW + 1)'(oct_r);
    if (oct_inc > (CW + 1)'(span_r)) begin
      oct_sel = '0;
    end else begin
      oct_sel = oct_inc[SPAN_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cidx_nxt   = cidx_r;
    span_nxt   = span_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    oct_nxt    = oct_r;
    run_nxt    = run_r;
    lvel_nxt   = lvel_r;
    lmidi_nxt  = lmidi_r;
    lcv_nxt    = lcv_r;
    ka_nxt     = ka_r;
    kb_nxt     = kb_r;
    note_nxt   = note_r;
    semi_nxt   = semi_r;
    pend_nxt   = pend_r;
    res_nxt    = res_r;
    rkind_nxt  = rkind_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    okind_nxt  = okind_r;
    rd_addr    = ka_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = ka_r[AW-1:0];
    wr_data    = note_r;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_OCTAVE_SPAN) begin
        span_nxt = cfg_pwdata[SPAN_W-1:0];
      end else begin
        cidx_nxt = cfg_pwdata[CIDX_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          note_nxt    = in_item.note_number;
          rkind_nxt   = KIND_PASS;
          res_nxt     = narp_out_t'(in_tdata);
          res_nxt.pad = 1'b0;
          pend_nxt    = 1'b0;
          state_nxt   = ST_EMIT;
          if (in_tuser == ACT_NOTE) begin
            pend_nxt = (in_item.note_channel != arp_chan);
            if (in_item.length_unknown) begin
              if (in_item.is_off) begin
                ka_nxt    = '0;
                kb_nxt    = '0;
                state_nxt = ST_REM_RD;
              end else begin
                if (!run_r) begin
                  pos_nxt = '0;
                  oct_nxt = '0;
                  run_nxt = 1'b1;
                end
                if (count_r == '0) begin
                  lvel_nxt  = in_item.note_velocity;
                  lmidi_nxt = in_item.to_midi;
                  lcv_nxt   = in_item.to_cv;
                end
                if (count_r < CNT_FULL) begin
                  ka_nxt    = count_r;
                  state_nxt = ST_INS_RD;
                end
              end
            end
          end else if (run_r && (count_r != '0)) begin
            if (pos_r >= count_r) begin
              pos_nxt = '0;
            end
            oct_nxt   = oct_sel;
            semi_nxt  = oct_to_semi(oct_sel);
            state_nxt = ST_TICK_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (ka_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_EMIT;
        end else begin
          rd_addr   = AW'(ka_r - CW'(1));
          state_nxt = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        wr_en = 1'b1;
        if (mem_rd_r > note_r) begin
          wr_data   = mem_rd_r;
          ka_nxt    = ka_r - CW'(1);
          state_nxt = ST_INS_RD;
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = ST_EMIT;
        end
      end
      ST_REM_RD: begin
        if (ka_r >= count_r) begin
          count_nxt = kb_r;
          if (kb_r == '0) begin
            run_nxt = 1'b0;
          end
          state_nxt = ST_EMIT;
        end else begin
          rd_addr   = ka_r[AW-1:0];
          state_nxt = ST_REM_WR;
        end
      end
      ST_REM_WR: begin
        wr_addr = kb_r[AW-1:0];
        wr_data = mem_rd_r;
        if (mem_rd_r != note_r) begin
          wr_en  = 1'b1;
          kb_nxt = kb_r + CW'(1);
        end
        ka_nxt    = ka_r + CW'(1);
        state_nxt = ST_REM_RD;
      end
      ST_TICK_RD: begin
        rd_addr   = pos_r[AW-1:0];
        state_nxt = ST_TICK_AD;
      end
      ST_TICK_AD: begin
        pos_nxt   = pos_r + CW'(1);
        rkind_nxt = KIND_ARP;
        pend_nxt  = (sum <= {1'b0, NOTE_MAX});
        res_nxt   = '{pad: 1'b0, out_cv: lcv_r, out_midi: lmidi_r,
                      out_length_unknown: 1'b0, out_off: 1'b0,
                      out_velocity: lvel_r, out_note: sum[NOTE_W-1:0],
                      out_channel: arp_chan};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!pend_r) begin
          state_nxt = ST_IDLE;
        end else if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = res_r;
          okind_nxt  = rkind_r;
          pend_nxt   = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cidx_r   <= '0;
      span_r   <= SPAN_W'(1);
      count_r  <= '0;
      pos_r    <= '0;
      oct_r    <= '0;
      run_r    <= 1'b0;
      lvel_r   <= '0;
      lmidi_r  <= 1'b0;
      lcv_r    <= 1'b0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cidx_r   <= cidx_nxt;
      span_r   <= span_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      oct_r    <= oct_nxt;
      run_r    <= run_nxt;
      lvel_r   <= lvel_nxt;
      lmidi_r  <= lmidi_nxt;
      lcv_r    <= lcv_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ka_r    <= ka_nxt;
    kb_r    <= kb_nxt;
    note_r  <= note_nxt;
    semi_r  <= semi_nxt;
    res_r   <= res_nxt;
    rkind_r <= rkind_nxt;
    odata_r <= odata_nxt;
    okind_r <= okind_nxt;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for note_arpeggiator_up: directed and random note events and ticks,
// predicted by an in-bench model of the held-note store and step positions.
// Depends on narp_pkg and the note_arpeggiator_up RTL.
module testbench;
  import narp_pkg::*;

  typedef struct packed {
    logic      kind;
    narp_out_t note;
  } arp_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [APB_AW-1:0]  cfg_paddr;
  logic [APB_DW-1:0]  cfg_pwdata;
  logic [APB_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  // Predicted copy of the block's configuration and state.
  logic [CIDX_W-1:0] m_chan_idx;
  logic [SPAN_W-1:0] m_span;
  logic [NOTE_W-1:0] m_held [MAX_HELD_DEF];
  logic [3:0]        m_count;
  logic [3:0]        m_note_pos;
  logic [SPAN_W-1:0] m_oct_pos;
  logic              m_running;
  logic [VEL_W-1:0]  m_vel;
  logic              m_midi;
  logic              m_cv;

  arp_result_t due_notes[$];

  int errors;
  int n_items;
  int n_results;
  int n_arp;
  int n_cfg;
  int n_holds;
  int tx_run;
  int rx_run;
  int rx_hold;
  bit tx_no_gap;

  note_arpeggiator_up uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[note_arpeggiator_up] ERROR");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] arp_channel();
    return CHAN_W'(m_chan_idx) + CHAN_W'(1);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic queue_result(input arp_result_t r);
    due_notes = {due_notes, r};
  endtask

  // Long stretches without any pause are mixed in with random pauses.
  task automatic draw_pause(inout int run, output int cycles);
    if (run == 0 && $urandom_range(0, 15) == 0) begin
      run = $urandom_range(8, 40);
    end
    if (run > 0) begin
      run--;
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 17);
    end
  endtask

  task automatic predict_arp(input logic act, input narp_in_t f);
    arp_result_t r;
    int oct;
    int value;
    int pos;
    int w;
    r = '0;
    if (act == ACT_NOTE) begin
      if (f.note_channel != arp_channel()) begin
        r.kind                    = KIND_PASS;
        r.note.out_channel        = f.note_channel;
        r.note.out_note           = f.note_number;
        r.note.out_velocity       = f.note_velocity;
        r.note.out_off            = f.is_off;
        r.note.out_length_unknown = f.length_unknown;
        r.note.out_midi           = f.to_midi;
        r.note.out_cv             = f.to_cv;
        queue_result(r);
      end
      if (f.length_unknown) begin
        if (f.is_off) begin
          w = 0;
          for (int i = 0; i < m_count; i++) begin
            if (m_held[i] != f.note_number) begin
              m_held[w] = m_held[i];
              w++;
            end
          end
          m_count = 4'(w);
          if (m_count == 0) m_running = 1'b0;
        end else begin
          if (!m_running) begin
            m_note_pos = '0;
            m_oct_pos  = '0;
            m_running  = 1'b1;
          end
          if (m_count == 0) begin
            m_vel  = f.note_velocity;
            m_midi = f.to_midi;
            m_cv   = f.to_cv;
          end
          if (m_count < MAX_HELD_DEF) begin
            pos = m_count;
            while (pos > 0 && m_held[pos-1] > f.note_number) begin
              m_held[pos] = m_held[pos-1];
              pos--;
            end
            m_held[pos] = f.note_number;
            m_count++;
          end
        end
      end
    end else if (m_running && m_count != 0) begin
      oct = m_oct_pos;
      if (m_note_pos >= m_count) begin
        m_note_pos = '0;
        oct++;
      end
      if (oct > m_span) oct = 0;
      m_oct_pos = SPAN_W'(oct);
      value = int'(m_held[m_note_pos]) + 12 * oct;
      m_note_pos++;
      if (value <= 127) begin
        r.kind              = KIND_ARP;
        r.note.out_channel  = arp_channel();
        r.note.out_note     = NOTE_W'(value);
        r.note.out_velocity = m_vel;
        r.note.out_midi     = m_midi;
        r.note.out_cv       = m_cv;
        queue_result(r);
      end
    end
  endtask

  // Valid is left high after an item; the next call either keeps it high or lowers it.
  task automatic send_item(input logic act, input narp_in_t f);
    int gap;
    if (tx_no_gap) begin
      gap = 0;
    end else begin
      draw_pause(tx_run, gap);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_arp(act, f);
    n_items++;
  endtask

  task automatic send_note(input logic [CHAN_W-1:0] chan, input logic [NOTE_W-1:0] num,
                           input logic [VEL_W-1:0] vel, input logic off, input logic len,
                           input logic midi, input logic cv);
    narp_in_t f;
    f = '0;
    f.note_channel   = chan;
    f.note_number    = num;
    f.note_velocity  = vel;
    f.is_off         = off;
    f.length_unknown = len;
    f.to_midi        = midi;
    f.to_cv          = cv;
    send_item(ACT_NOTE, f);
  endtask

  task automatic send_tick();
    narp_in_t f;
    f = {1'b0, 23'($urandom())};
    send_item(ACT_TICK, f);
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_notes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_CHANNEL_INDEX) ? 32'hF : 32'h7;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= (value & mask) | ($urandom() & ~mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_CHANNEL_INDEX) begin
      m_chan_idx = value[CIDX_W-1:0];
    end else begin
      m_span = value[SPAN_W-1:0];
    end
    n_cfg++;
  endtask

  task automatic test_defaults();
    send_tick();
    send_note(arp_channel(), 7'd5, 7'd9, 1'b1, 1'b1, 1'b0, 1'b0);
    send_note(5'd0, 7'd127, 7'd127, 1'b1, 1'b0, 1'b1, 1'b1);
    send_note(5'd31, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_note(5'd16, 7'd64, 7'd100, 1'b0, 1'b1, 1'b0, 1'b1);
    send_note(arp_channel(), 7'd10, 7'd33, 1'b0, 1'b0, 1'b1, 1'b1);
    send_note(arp_channel(), 7'd120, 7'd5, 1'b0, 1'b1, 1'b1, 1'b0);
    send_note(arp_channel(), 7'd64, 7'd77, 1'b0, 1'b1, 1'b1, 1'b1);
    repeat (6) send_tick();
    send_note(arp_channel(), 7'd64, 7'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick();
    send_note(arp_channel(), 7'd120, 7'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick();
  endtask

  task automatic test_octave_wrap();
    settle_block();
    cfg_write(REG_OCTAVE_SPAN, 32'd7);
    send_note(arp_channel(), 7'd40, 7'd90, 1'b0, 1'b1, 1'b1, 1'b1);
    repeat (3) send_tick();
    settle_block();
    cfg_write(REG_OCTAVE_SPAN, 32'd0);
    send_tick();
  endtask

  task automatic test_store_full();
    settle_block();
    cfg_write(REG_CHANNEL_INDEX, 32'd15);
    cfg_write(REG_OCTAVE_SPAN, 32'd7);
    send_note(5'd1, 7'd40, 7'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      send_note(arp_channel(), NOTE_W'(100 - 9 * i), VEL_W'(14 * i), 1'b0, 1'b1,
                1'(i), 1'(i + 1));
    end
    send_tick();
  endtask

  task automatic test_backpressure();
    narp_in_t f;
    settle_block();
    rx_hold   = 300;
    tx_no_gap = 1'b1;
    repeat (12) begin
      f = {1'b0, 23'($urandom())};
      while (f.note_channel == arp_channel()) f.note_channel = CHAN_W'($urandom());
      send_item(ACT_NOTE, f);
    end
    tx_no_gap = 1'b0;
    settle_block();
  endtask

  task automatic random_traffic(input int count);
    narp_in_t f;
    int r;
    logic [NOTE_W-1:0] num;
    for (int k = 0; k < count; k++) begin
      r   = $urandom_range(0, 99);
      num = ($urandom_range(0, 3) == 0) ? NOTE_W'($urandom_range(96, 127)) : NOTE_W'($urandom());
      f   = {1'b0, 23'($urandom())};
      if (r < 35) begin
        send_item(ACT_TICK, f);
      end else if (r < 62) begin
        if ($urandom_range(0, 4) != 0) f.note_channel = arp_channel();
        f.note_number    = num;
        f.is_off         = 1'b0;
        f.length_unknown = 1'b1;
        send_item(ACT_NOTE, f);
      end else if (r < 82) begin
        if ($urandom_range(0, 4) != 0) f.note_channel = arp_channel();
        if (m_count != 0 && $urandom_range(0, 5) != 0) begin
          f.note_number = m_held[$urandom_range(0, m_count - 1)];
        end
        f.is_off         = 1'b1;
        f.length_unknown = 1'b1;
        send_item(ACT_NOTE, f);
      end else if (r < 92) begin
        while (f.note_channel == arp_channel()) f.note_channel = CHAN_W'($urandom());
        f.length_unknown = ($urandom_range(0, 3) == 0);
        send_item(ACT_NOTE, f);
      end else begin
        send_item(ACT_NOTE, f);
      end
    end
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      settle_block();
      case (p)
        0: begin
          cfg_write(REG_CHANNEL_INDEX, 32'd0);
          cfg_write(REG_OCTAVE_SPAN, 32'd7);
        end
        1: begin
          cfg_write(REG_CHANNEL_INDEX, 32'd15);
          cfg_write(REG_OCTAVE_SPAN, 32'd0);
        end
        default: begin
          cfg_write(REG_CHANNEL_INDEX, $urandom_range(0, 15));
          cfg_write(REG_OCTAVE_SPAN, $urandom_range(0, 7));
        end
      endcase
      random_traffic(220);
    end
  endtask

  initial begin
    arp_result_t got;
    arp_result_t want;
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        n_holds++;
      end
      draw_pause(rx_run, stall);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.kind = out_tuser;
      got.note = out_tdata;
      n_results++;
      if (got.kind == KIND_ARP) n_arp++;
      if (due_notes.size() == 0) begin
        report_mismatch("result with nothing due, note", got.note.out_note, -1);
      end else begin
        want = due_notes.pop_front();
        if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.note.out_channel != want.note.out_channel)
          report_mismatch("channel", got.note.out_channel, want.note.out_channel);
        if (got.note.out_note != want.note.out_note)
          report_mismatch("note", got.note.out_note, want.note.out_note);
        if (got.note.out_velocity != want.note.out_velocity)
          report_mismatch("velocity", got.note.out_velocity, want.note.out_velocity);
        if (got.note.out_off != want.note.out_off)
          report_mismatch("off", got.note.out_off, want.note.out_off);
        if (got.note.out_length_unknown != want.note.out_length_unknown)
          report_mismatch("length_unknown", got.note.out_length_unknown,
                          want.note.out_length_unknown);
        if (got.note.out_midi != want.note.out_midi)
          report_mismatch("midi", got.note.out_midi, want.note.out_midi);
        if (got.note.out_cv != want.note.out_cv)
          report_mismatch("cv", got.note.out_cv, want.note.out_cv);
        if (got.note.pad !== 1'b0) report_mismatch("pad", got.note.pad, 0);
      end
    end
  end

  initial begin
    in_tvalid   <= 1'b0;
    in_tuser    <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    m_chan_idx  = '0;
    m_span      = SPAN_W'(1);
    m_count     = '0;
    m_note_pos  = '0;
    m_oct_pos   = '0;
    m_running   = 1'b0;
    m_vel       = '0;
    m_midi      = 1'b0;
    m_cv        = 1'b0;
    for (int i = 0; i < MAX_HELD_DEF; i++) m_held[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_octave_wrap();
    test_store_full();
    test_backpressure();
    test_random_settings();
    settle_block();

    $display("Sent %0d items and %0d register writes; checked %0d results, %0d of them arpeggiated.",
             n_items, n_cfg, n_results, n_arp);
    $display("Output was held off for long stretches %0d time(s); %0d mismatches found.",
             n_holds, errors);
    if (errors == 0) begin
      $display("[note_arpeggiator_up] OK");
    end else begin
      $display("[note_arpeggiator_up] ERROR");
    end
    $finish;
  end

endmodule
